[hdl/slwp_pkg.sv]
// Shared constants, tables and stage types of the skewed LFO wave point generator.
`timescale 1ns / 1ps
package slwp_pkg;

    // Field widths
    localparam int IDX_W    = 7;
    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 7;
    localparam int STEP_W   = 16;
    localparam int WAVE_W   = 3;
    localparam int SKEW_W   = 9;
    localparam int PERIOD_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PERIOD_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKEW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

    // Waveform codes
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_REV_SAW  = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd5;

    // Reset values
    localparam logic [SKEW_W-1:0] SKEW_RESET = 9'd180;

    // Subdivision selection
    localparam logic [PERIOD_W-1:0] PERIOD_FINE   = 20'd2400;
    localparam logic [PERIOD_W-1:0] PERIOD_MEDIUM = 20'd600;
    localparam logic [COUNT_W-1:0]  POINTS_FINE   = 7'd120;
    localparam logic [COUNT_W-1:0]  POINTS_MEDIUM = 7'd60;
    localparam logic [COUNT_W-1:0]  POINTS_COARSE = 7'd30;

    // period / count = (period >> k) / 15, done as multiply by reciprocal
    localparam int STEP_X_W     = 19;
    localparam int STEP_RECIP_W = 20;
    localparam int STEP_PROD_W  = STEP_X_W + STEP_RECIP_W;
    localparam int STEP_SHIFT   = 23;
    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP = 20'd559241;

    // Angles in degrees
    localparam int ANGLE_W      = 9;
    localparam int ANGLE_FULL_W = 11;
    localparam int DEG_STEP_W   = 4;
    localparam logic [ANGLE_W-1:0] DEG_FULL = 9'd360;
    localparam logic [ANGLE_W-1:0] SKEW_MIN = 9'd1;
    localparam logic [ANGLE_W-1:0] SKEW_MAX = 9'd359;
    localparam int DEG_HALF = 180;

    // Phase warp division: (numer << FRAC_W) / denom
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = 17;
    localparam int SPAN_W     = 10;
    localparam int QUO_W      = 25;
    localparam int DIV_STEPS  = 5;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS;

    // Cycles from accept edge to the edge that samples the result strobe
    localparam int PIPE_LATENCY = 4 + DIV_STAGES;

    // Phase landmarks in Q16
    localparam logic [QUO_W-1:0] Q_DEG90  = QUO_W'(90 * (2 ** FRAC_W));
    localparam logic [QUO_W-1:0] Q_DEG180 = QUO_W'(180 * (2 ** FRAC_W));
    localparam logic [QUO_W-1:0] Q_DEG270 = QUO_W'(270 * (2 ** FRAC_W));

    // Wave shaping constants
    localparam int TRI_MAG_W = 23;
    localparam int SAW_MAG_W = 24;
    localparam int SHAPE_PROD_W = 27;
    localparam int V_W = 10;
    localparam logic [3:0] TRI_GAIN = 4'd10;
    localparam logic [2:0] SAW_GAIN = 3'd5;
    localparam int NINTH_W = 10;
    localparam logic [NINTH_W-1:0] NINTH_RECIP = 10'd911;
    localparam int NINTH_SHIFT = 13;
    localparam int MAG_W = 7;
    localparam int THIRD_W = 8;
    localparam logic [THIRD_W-1:0] THIRD_RECIP = 8'd171;
    localparam int THIRD_SHIFT = 9;
    localparam logic signed [LEVEL_W-1:0] LEVEL_FULL = 8'sd100;

    // Cosine levels, one entry per 3 degrees
    localparam int TABLE_POINTS = 120;
    localparam int CI_W = 7;
    localparam logic [CI_W:0] CI_MAX = (CI_W + 1)'(TABLE_POINTS - 1);
    localparam logic signed [LEVEL_W-1:0] COS_TABLE [0:TABLE_POINTS-1] = '{
        100, 99, 99, 98, 97, 96, 95, 93, 91, 89,
         86, 83, 80, 77, 74, 70, 66, 62, 58, 54,
         50, 45, 40, 35, 30, 25, 20, 15, 10,  5,
          0, -5,-10,-15,-20,-25,-30,-35,-40,-45,
        -50,-54,-58,-62,-66,-70,-74,-77,-80,-83,
        -86,-89,-91,-93,-95,-96,-97,-98,-99,-99,
       -100,-99,-99,-98,-97,-96,-95,-93,-91,-89,
        -86,-83,-80,-77,-74,-70,-66,-62,-58,-54,
        -50,-45,-40,-35,-30,-25,-20,-15,-10, -5,
          0,  5, 10, 15, 20, 25, 30, 35, 40, 45,
         50, 54, 58, 62, 66, 70, 74, 77, 80, 83,
         86, 89, 91, 93, 95, 96, 97, 98, 99, 99
    };

    // Operand word handed to the divider
    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic               a_le_s;
        logic [NUM_W-1:0]   numer;
        logic [SKEW_W-1:0]  denom;
    } slwp_div_in_t;

    // One divider stage: partial remainder and dividend/quotient shift word
    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic               a_le_s;
        logic [SKEW_W-1:0]  denom;
        logic [SKEW_W-1:0]  rem;
        logic [QUO_W-1:0]   bits;
    } slwp_div_st_t;

    // Warped phase word handed to the wave shaper
    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic               a_le_s;
        logic [QUO_W-1:0]   phase;
    } slwp_phase_t;

    // Subdivision count chosen by period time
    function automatic logic [COUNT_W-1:0] points_for(input logic [PERIOD_W-1:0] period);
        logic [COUNT_W-1:0] pts;
        if (period >= PERIOD_FINE)
            pts = POINTS_FINE;
        else if (period >= PERIOD_MEDIUM)
            pts = POINTS_MEDIUM;
        else
            pts = POINTS_COARSE;
        return pts;
    endfunction

endpackage

[hdl/slwp_phase.sv]
// Point angle and phase warp operands: two pipeline stages ahead of the divider.
`timescale 1ns / 1ps
module slwp_phase
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [slwp_pkg::IDX_W-1:0]    point_index,
    input  logic [slwp_pkg::COUNT_W-1:0]  points,
    input  logic [slwp_pkg::SKEW_W-1:0]   skew,
    output slwp_pkg::slwp_div_in_t        div_in
);
    import slwp_pkg::*;

    logic                    a_valid_reg;
    logic                    a_in_range_reg;
    logic                    a_in_range_next;
    logic [ANGLE_W-1:0]      a_angle_reg;
    logic [ANGLE_W-1:0]      a_angle_next;
    logic [DEG_STEP_W-1:0]   deg_step;
    logic [ANGLE_FULL_W-1:0] angle_full;

    slwp_div_in_t            div_in_reg;
    slwp_div_in_t            div_in_next;
    logic [SKEW_W-1:0]       s_clamped;
    logic [ANGLE_FULL_W-1:0] span_full;
    logic [SPAN_W-1:0]       span;
    logic                    a_le_s;

    // Stage A: degrees per point and point angle
    always_comb
    begin
        case (points)
            POINTS_FINE:   deg_step = 4'd3;
            POINTS_MEDIUM: deg_step = 4'd6;
            default:       deg_step = 4'd12;
        endcase
        angle_full      = ANGLE_FULL_W'(point_index) * ANGLE_FULL_W'(deg_step);
        a_angle_next    = angle_full[ANGLE_W-1:0];
        a_in_range_next = (point_index < points);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        a_angle_reg    <= a_angle_next;
        a_in_range_reg <= a_in_range_next;
    end

    // Stage B: clamp skew, pick warp segment, form numerator and divisor
    always_comb
    begin
        if (skew < SKEW_MIN)
            s_clamped = SKEW_MIN;
        else if (skew > SKEW_MAX)
            s_clamped = SKEW_MAX;
        else
            s_clamped = skew;

        a_le_s    = (a_angle_reg <= s_clamped);
        // a + 360 - 2s, positive whenever a is past the inflection
        span_full = ANGLE_FULL_W'(a_angle_reg) + ANGLE_FULL_W'(DEG_FULL)
                    - {1'b0, s_clamped, 1'b0};
        span      = span_full[SPAN_W-1:0];

        div_in_next.valid    = a_valid_reg;
        div_in_next.in_range = a_in_range_reg;
        div_in_next.a_le_s   = a_le_s;
        if (a_le_s)
        begin
            div_in_next.numer = NUM_W'(a_angle_reg) * NUM_W'(DEG_HALF);
            div_in_next.denom = s_clamped;
        end
        else
        begin
            div_in_next.numer = NUM_W'(span) * NUM_W'(DEG_HALF);
            div_in_next.denom = DEG_FULL - s_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_in_reg <= '0;
        end
        else
        begin
            div_in_reg <= div_in_next;
        end
    end

    assign div_in = div_in_reg;

endmodule

[hdl/slwp_div.sv]
// Pipelined restoring divider: warped phase in Q16, several quotient bits per stage.
`timescale 1ns / 1ps
module slwp_div
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  slwp_pkg::slwp_div_in_t  div_in,
    output slwp_pkg::slwp_phase_t   phase_out
);
    import slwp_pkg::*;

    slwp_div_st_t st [0:DIV_STAGES];

    // Dividend is numer << FRAC_W; its top bits are already below the divisor
    always_comb
    begin
        st[0].valid    = div_in.valid;
        st[0].in_range = div_in.in_range;
        st[0].a_le_s   = div_in.a_le_s;
        st[0].denom    = div_in.denom;
        st[0].rem      = SKEW_W'(div_in.numer[NUM_W-1:QUO_W-FRAC_W]);
        st[0].bits     = {div_in.numer[QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        slwp_div_st_t st_next;

        // DIV_STEPS shift-compare-subtract steps
        always_comb
        begin : steps
            logic [SKEW_W:0]   trial;
            logic [SKEW_W-1:0] rem;
            logic [QUO_W-1:0]  bits;
            logic              qbit;
            rem  = st[k].rem;
            bits = st[k].bits;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                trial = {rem, bits[QUO_W-1]};
                qbit  = (trial >= {1'b0, st[k].denom});
                if (qbit)
                    trial = trial - {1'b0, st[k].denom};
                rem  = trial[SKEW_W-1:0];
                bits = {bits[QUO_W-2:0], qbit};
            end
            st_next       = st[k];
            st_next.rem   = rem;
            st_next.bits  = bits;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st[k+1] <= '0;
            end
            else
            begin
                st[k+1] <= st_next;
            end
        end
    end

    // After the last stage the shift word holds the quotient
    assign phase_out.valid    = st[DIV_STAGES].valid;
    assign phase_out.in_range = st[DIV_STAGES].in_range;
    assign phase_out.a_le_s   = st[DIV_STAGES].a_le_s;
    assign phase_out.phase    = st[DIV_STAGES].bits;

endmodule

[hdl/slwp_shape.sv]
// Wave shaper: turns the warped phase into the level of the selected waveform.
`timescale 1ns / 1ps
module slwp_shape
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  slwp_pkg::slwp_phase_t               phase_in,
    input  logic [slwp_pkg::WAVE_W-1:0]         wave,
    output logic                                done,
    output logic signed [slwp_pkg::LEVEL_W-1:0] level
);
    import slwp_pkg::*;

    logic [QUO_W-1:0]   q;
    logic [ANGLE_W-1:0] q_deg;
    logic [ANGLE_W+THIRD_W-1:0] third_prod;
    logic [CI_W:0]      ci_raw;
    logic [CI_W-1:0]    ci_next;
    logic [QUO_W-1:0]   tri_diff;
    logic               tri_neg;
    logic [QUO_W-1:0]   saw_diff;
    logic               saw_neg;
    logic [SHAPE_PROD_W-1:0] tri_prod;
    logic [SHAPE_PROD_W-1:0] saw_prod;
    logic [V_W-1:0]     v_next;
    logic               neg_next;

    logic               c_valid_reg;
    logic               c_in_range_reg;
    logic               c_a_le_s_reg;
    logic [WAVE_W-1:0]  c_wave_reg;
    logic [CI_W-1:0]    c_ci_reg;
    logic [V_W-1:0]     c_v_reg;
    logic               c_neg_reg;

    logic [V_W+NINTH_W-1:0]   ninth_prod;
    logic [MAG_W-1:0]         mag;
    logic signed [LEVEL_W-1:0] ramp_level;
    logic signed [LEVEL_W-1:0] level_next;
    logic signed [LEVEL_W-1:0] level_reg;
    logic                     done_reg;

    // Stage C: table index and scaled ramp magnitudes
    always_comb
    begin
        q          = phase_in.phase;
        q_deg      = q[QUO_W-1:FRAC_W];
        third_prod = (ANGLE_W+THIRD_W)'(q_deg) * (ANGLE_W+THIRD_W)'(THIRD_RECIP);
        ci_raw     = third_prod[THIRD_SHIFT +: CI_W+1];
        ci_next    = (ci_raw > CI_MAX) ? CI_MAX[CI_W-1:0] : ci_raw[CI_W-1:0];

        // Triangle: distance to 270 above the half turn, else to 90
        if (q > Q_DEG180)
        begin
            if (q >= Q_DEG270)
            begin
                tri_diff = q - Q_DEG270;
                tri_neg  = 1'b1;
            end
            else
            begin
                tri_diff = Q_DEG270 - q;
                tri_neg  = 1'b0;
            end
        end
        else
        begin
            if (q <= Q_DEG90)
            begin
                tri_diff = Q_DEG90 - q;
                tri_neg  = 1'b1;
            end
            else
            begin
                tri_diff = q - Q_DEG90;
                tri_neg  = 1'b0;
            end
        end

        // Saw: signed distance from the half turn
        if (q >= Q_DEG180)
        begin
            saw_diff = q - Q_DEG180;
            saw_neg  = 1'b0;
        end
        else
        begin
            saw_diff = Q_DEG180 - q;
            saw_neg  = 1'b1;
        end

        tri_prod = SHAPE_PROD_W'(tri_diff[TRI_MAG_W-1:0]) * SHAPE_PROD_W'(TRI_GAIN);
        saw_prod = SHAPE_PROD_W'(saw_diff[SAW_MAG_W-1:0]) * SHAPE_PROD_W'(SAW_GAIN);

        case (wave)
            WAVE_TRIANGLE:
            begin
                v_next   = tri_prod[FRAC_W +: V_W];
                neg_next = tri_neg;
            end
            WAVE_REV_SAW:
            begin
                v_next   = saw_prod[FRAC_W +: V_W];
                neg_next = !saw_neg;
            end
            default:
            begin
                v_next   = saw_prod[FRAC_W +: V_W];
                neg_next = saw_neg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= phase_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        c_in_range_reg <= phase_in.in_range;
        c_a_le_s_reg   <= phase_in.a_le_s;
        c_wave_reg     <= wave;
        c_ci_reg       <= ci_next;
        c_v_reg        <= v_next;
        c_neg_reg      <= neg_next;
    end

    // Stage D: divide ramp by nine, select level, output register
    always_comb
    begin
        ninth_prod = (V_W+NINTH_W)'(c_v_reg) * (V_W+NINTH_W)'(NINTH_RECIP);
        mag        = ninth_prod[NINTH_SHIFT +: MAG_W];
        ramp_level = c_neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        case (c_wave_reg)
            WAVE_SINE:     level_next = -COS_TABLE[c_ci_reg];
            WAVE_TRIANGLE: level_next = ramp_level;
            WAVE_SQUARE:   level_next = c_a_le_s_reg ? -LEVEL_FULL : LEVEL_FULL;
            WAVE_REV_SAW:  level_next = ramp_level;
            WAVE_SAW:      level_next = ramp_level;
            default:       level_next = '0;
        endcase
        if (!c_in_range_reg)
            level_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
    end

    assign done  = done_reg;
    assign level = level_reg;

endmodule

[hdl/skewed_lfo_wave_point.sv]
// Top level of the skewed LFO wave point generator: registers, step time and pipeline.
`timescale 1ns / 1ps
// A point index is taken on every clock edge where start is high; busy never rises,
// so one word can enter each cycle. Each word passes two angle stages, five divider
// stages of five quotient bits each and two shaping stages, and its result is shown
// for one cycle with done high; the receiver cannot stall, so results must be
// captured as they come. Register writes take effect on the next word; step_time
// follows a period write through the step product and step registers. Write
// registers only while no word is in flight.
module skewed_lfo_wave_point
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [slwp_pkg::IDX_W-1:0]           point_index,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [slwp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [slwp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 done,
    output logic signed [slwp_pkg::LEVEL_W-1:0]  level,
    output logic [slwp_pkg::COUNT_W-1:0]         points_in_use,
    output logic [slwp_pkg::STEP_W-1:0]          step_time
);
    import slwp_pkg::*;

    logic [WAVE_W-1:0]      wave_reg;
    logic [SKEW_W-1:0]      skew_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [COUNT_W-1:0]     points;
    logic [STEP_X_W-1:0]    step_x;
    logic [STEP_PROD_W-1:0] step_prod_reg;
    logic [STEP_PROD_W-1:0] step_prod_next;
    logic [STEP_W-1:0]      step_reg;
    logic                   accept;
    slwp_div_in_t           div_in;
    slwp_phase_t            phase;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg   <= '0;
            skew_reg   <= SKEW_RESET;
            period_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WAVE:   wave_reg   <= cfg_data[WAVE_W-1:0];
                CFG_SKEW:   skew_reg   <= cfg_data[SKEW_W-1:0];
                CFG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                default:    ;
            endcase
        end
    end

    // Subdivision count and step time: period / count = (period >> k) / 15
    always_comb
    begin
        points = points_for(period_reg);
        case (points)
            POINTS_FINE:   step_x = STEP_X_W'(period_reg >> 3);
            POINTS_MEDIUM: step_x = STEP_X_W'(period_reg >> 2);
            default:       step_x = STEP_X_W'(period_reg >> 1);
        endcase
        step_prod_next = STEP_PROD_W'(step_x) * STEP_PROD_W'(STEP_RECIP);
    end

    always_ff @(posedge clk)
    begin
        step_prod_reg <= step_prod_next;
        step_reg      <= step_prod_reg[STEP_SHIFT +: STEP_W];
    end

    // Point pipeline
    slwp_phase u_phase
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .point_index (point_index),
        .points      (points),
        .skew        (skew_reg),
        .div_in      (div_in)
    );

    slwp_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .div_in    (div_in),
        .phase_out (phase)
    );

    slwp_shape u_shape
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .phase_in (phase),
        .wave     (wave_reg),
        .done     (done),
        .level    (level)
    );

    assign points_in_use = points;
    assign step_time     = step_reg;

endmodule

[hdl/slwp_checker.sv]
// Port-level checker for the skewed LFO wave point generator, bound to the top level.
`timescale 1ns / 1ps
module slwp_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [slwp_pkg::IDX_W-1:0]           point_index,
    input  logic                                 done,
    input  logic signed [slwp_pkg::LEVEL_W-1:0]  level,
    input  logic [slwp_pkg::COUNT_W-1:0]         points_in_use
);
    import slwp_pkg::*;

    // Every word taken comes back after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("word taken but no result after pipeline latency");

    // No result without a word taken that many cycles before
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result strobe without a matching word");

    // Levels stay within full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (level >= -LEVEL_FULL) && (level <= LEVEL_FULL))
    else $error("level outside full scale");

    // Index past the subdivision count gives zero level
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(point_index, PIPE_LATENCY) >= points_in_use)) |-> (level == '0))
    else $error("nonzero level for index past subdivision count");

endmodule

bind skewed_lfo_wave_point slwp_checker u_slwp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .point_index   (point_index),
    .done          (done),
    .level         (level),
    .points_in_use (points_in_use)
);
